[rtl/lidar_node_stream_parser_top_defines.svh]
// Assertion macros for the lidar node stream parser.
// Depends on nothing; the asserting module must have clk and arst_n in scope.
`ifndef LIDAR_NODE_STREAM_PARSER_TOP_DEFINES_SVH
`define LIDAR_NODE_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LNSP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lnsp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LNSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lnsp next-cycle check failed");

`endif

[rtl/lnsp_pkg.sv]
// Shared types and constants for the lidar node stream parser.
// No dependencies.
`timescale 1ns / 1ps

package lnsp_pkg;

	localparam int WINDOW_DEPTH = 7;
	localparam int NODE_LEN     = 5;
	localparam int POS_W        = $clog2(NODE_LEN);

	localparam logic [7:0] SYNC_FIRST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;

	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

	// command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// node byte positions that carry fields
	localparam logic [POS_W-1:0] POS_FLAGS   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_CHECK   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_DIST_LO = POS_W'(3);
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(NODE_LEN - 1);

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        locked;
		logic        node_complete;
		logic        node_accepted;
		logic        scan_started;
		logic [31:0] byte_count;
		logic [31:0] nodes_parsed;
		logic [15:0] scan_samples;
		logic [15:0] last_scan_samples;
		logic [31:0] last_node_ms;
		logic        link_live;
	} out_item_t;

	typedef struct packed {
		logic locked;
		logic complete;
		logic accepted;
		logic start;
	} frame_res_t;

	typedef struct packed {
		logic [31:0] byte_count;
		logic [31:0] nodes_parsed;
		logic [15:0] scan_samples;
		logic [15:0] last_scan_samples;
		logic [31:0] last_node_ms;
		logic        link_live;
	} stats_res_t;

endpackage

[rtl/lidar_node_stream_parser_top.sv]
// Top level of the lidar node stream parser: input register, framing,
// statistics and result register. Depends on lnsp_pkg, lnsp_frame,
// lnsp_stats and lidar_node_stream_parser_top_defines.svh.
//
// Usage:
//   item channel (item_valid / item_ready / item): one word per received
//   serial byte (command = 0) or per millisecond tick (command = 1).
//   result channel (result_valid / result_ready / result): exactly one
//   word per input word, in order, with the lock flag, node verdict,
//   counters, last node time and stream-active flag after that word.
//   timeout_we / timeout_wdata: write the stream timeout in ms (reset 500);
//   write only while no word is in flight.
// Path: an accepted word is registered in the input register, then passes
// once through framing and counters into the result register.
// Throughput: one word per cycle while result_ready keeps the result
// register draining; the counter/time state closes its loop within a
// single pass, so back-to-back words are processed in turn.
// Stall: when result_ready is low with a result held, the input register
// holds one more word and item_ready drops until the result is taken.
// Reset: arst_n clears the window, lock, node position, counters, time and
// both pipeline valid flags; the timeout returns to 500.
`timescale 1ns / 1ps
`include "lidar_node_stream_parser_top_defines.svh"

module lidar_node_stream_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  lnsp_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output lnsp_pkg::out_item_t result,
	input  logic                timeout_we,
	input  logic [15:0]         timeout_wdata
);

	lnsp_pkg::in_item_t   item_s1;
	logic                 valid_s1;
	lnsp_pkg::out_item_t  result_s2;
	logic                 valid_s2;
	logic [15:0]          timeout_q;
	logic                 advance;
	logic                 is_tick;
	lnsp_pkg::frame_res_t frame_res;
	lnsp_pkg::stats_res_t stats_res;

	// advance the held word when the result register is free or draining
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign is_tick    = (item_s1.command == lnsp_pkg::CMD_TICK);

	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= lnsp_pkg::TIMEOUT_RESET;
		end else if (timeout_we) begin
			timeout_q <= timeout_wdata;
		end
	end

	// input register: hold one word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	lnsp_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_step (advance && !is_tick),
		.rx_byte   (item_s1.rx_byte),
		.res       (frame_res)
	);

	lnsp_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.tick     (is_tick),
		.accepted (frame_res.accepted),
		.start    (frame_res.start),
		.timeout  (timeout_q),
		.res      (stats_res)
	);

	// result register: drop valid once taken, reload on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.locked            <= frame_res.locked;
			result_s2.node_complete     <= frame_res.complete;
			result_s2.node_accepted     <= frame_res.accepted;
			result_s2.scan_started      <= frame_res.start;
			result_s2.byte_count        <= stats_res.byte_count;
			result_s2.nodes_parsed      <= stats_res.nodes_parsed;
			result_s2.scan_samples      <= stats_res.scan_samples;
			result_s2.last_scan_samples <= stats_res.last_scan_samples;
			result_s2.last_node_ms      <= stats_res.last_node_ms;
			result_s2.link_live         <= stats_res.link_live;
		end
	end

	// a start flag only comes with an accepted, complete node
	`LNSP_ASSERT_NOW(a_start_needs_accept, valid_s2 && result_s2.scan_started,
		result_s2.node_accepted && result_s2.node_complete)
	// lock is sticky across results
	`LNSP_ASSERT_NEXT(a_lock_sticky, valid_s2 && result_s2.locked,
		!valid_s2 || result_s2.locked)
	// a byte always reports the stream as active
	`LNSP_ASSERT_NEXT(a_byte_active, advance && !is_tick,
		valid_s2 && result_s2.link_live)

endmodule

[rtl/lnsp_frame.sv]
// Sync window, lock flag and five-byte node framing/judging.
// Depends on lnsp_pkg.
`timescale 1ns / 1ps

module lnsp_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_step,
	input  logic [7:0]           rx_byte,
	output lnsp_pkg::frame_res_t res
);

	logic [7:0]                 win_q   [lnsp_pkg::WINDOW_DEPTH];
	logic [7:0]                 win_nxt [lnsp_pkg::WINDOW_DEPTH];
	logic                       lock_q;
	logic [lnsp_pkg::POS_W-1:0] pos_q;
	logic [1:0]                 flags_q;
	logic                       chk_q;
	logic [7:0]                 dist_lo_q;
	logic                       sync_hit;
	logic                       pass;
	logic                       complete;

	// shift the window by one byte
	always_comb begin
		for (int i = 0; i < lnsp_pkg::WINDOW_DEPTH - 1; i++) begin
			win_nxt[i] = win_q[i + 1];
		end
		win_nxt[lnsp_pkg::WINDOW_DEPTH - 1] = rx_byte;
	end

	assign sync_hit = (win_nxt[0] == lnsp_pkg::SYNC_FIRST) &&
		(win_nxt[1] == lnsp_pkg::SYNC_SECOND);

	assign complete = byte_step && (pos_q == lnsp_pkg::POS_LAST);
	assign pass     = (flags_q[0] != flags_q[1]) && chk_q && ({rx_byte, dist_lo_q} != 16'd0);

	assign res.locked   = lock_q || (byte_step && sync_hit);
	assign res.complete = complete;
	assign res.accepted = complete && pass;
	assign res.start    = complete && pass && flags_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lnsp_pkg::WINDOW_DEPTH; i++) begin
				win_q[i] <= 8'd0;
			end
			lock_q    <= 1'b0;
			pos_q     <= '0;
			flags_q   <= 2'd0;
			chk_q     <= 1'b0;
			dist_lo_q <= 8'd0;
		end else if (byte_step) begin
			win_q  <= win_nxt;
			lock_q <= res.locked;
			case (pos_q)
				lnsp_pkg::POS_FLAGS:   flags_q   <= rx_byte[1:0];
				lnsp_pkg::POS_CHECK:   chk_q     <= rx_byte[0];
				lnsp_pkg::POS_DIST_LO: dist_lo_q <= rx_byte;
				default: ;
			endcase
			if (pos_q == lnsp_pkg::POS_LAST) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

[rtl/lnsp_stats.sv]
// Byte/node/scan counters, millisecond time and stream-active check.
// Depends on lnsp_pkg.
`timescale 1ns / 1ps

module lnsp_stats (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 tick,
	input  logic                 accepted,
	input  logic                 start,
	input  logic [15:0]          timeout,
	output lnsp_pkg::stats_res_t res
);

	logic [31:0] byte_total_q;
	logic [31:0] node_total_q;
	logic [15:0] scan_q;
	logic [15:0] prior_scan_q;
	logic [31:0] now_q;
	logic [31:0] last_byte_q;
	logic [31:0] last_node_q;

	logic [31:0] now_nxt;
	logic [31:0] last_byte_nxt;
	logic [31:0] elapsed;
	logic        byte_step;

	assign byte_step = advance && !tick;

	always_comb begin
		now_nxt       = now_q;
		last_byte_nxt = last_byte_q;
		res.byte_count        = byte_total_q;
		res.nodes_parsed      = node_total_q;
		res.scan_samples      = scan_q;
		res.last_scan_samples = prior_scan_q;
		res.last_node_ms      = last_node_q;
		if (advance && tick) begin
			now_nxt = now_q + 32'd1;
		end
		if (byte_step) begin
			last_byte_nxt  = now_q;
			res.byte_count = byte_total_q + 32'd1;
		end
		if (byte_step && accepted) begin
			res.nodes_parsed = node_total_q + 32'd1;
			res.last_node_ms = now_q;
			if (start) begin
				res.scan_samples = 16'd1;
				if (scan_q != 16'd0) begin
					res.last_scan_samples = scan_q;
				end
			end else begin
				res.scan_samples = scan_q + 16'd1;
			end
		end
		elapsed       = now_nxt - last_byte_nxt;
		res.link_live = (elapsed <= {16'd0, timeout});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_total_q <= 32'd0;
			node_total_q <= 32'd0;
			scan_q       <= 16'd0;
			prior_scan_q <= 16'd0;
			now_q        <= 32'd0;
			last_byte_q  <= 32'd0;
			last_node_q  <= 32'd0;
		end else if (advance) begin
			byte_total_q <= res.byte_count;
			node_total_q <= res.nodes_parsed;
			scan_q       <= res.scan_samples;
			prior_scan_q <= res.last_scan_samples;
			now_q        <= now_nxt;
			last_byte_q  <= last_byte_nxt;
			last_node_q  <= res.last_node_ms;
		end
	end

endmodule

[bench/tb_lidar_node_stream_parser_top.sv]
// Self-checking bench for lidar_node_stream_parser_top: drives byte and tick
// words, predicts every status word and compares it field by field.
// Depends on lnsp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_lidar_node_stream_parser_top;

	localparam int PIPE_LAT = 2;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                item_valid    = 1'b0;
	logic                item_ready;
	lnsp_pkg::in_item_t  item          = '0;
	logic                result_valid;
	logic                result_ready  = 1'b0;
	lnsp_pkg::out_item_t result;
	logic                timeout_we    = 1'b0;
	logic [15:0]         timeout_wdata = '0;

	// words waiting to be sent, and status words still owed by the block
	lnsp_pkg::in_item_t  rx_pending[$];
	lnsp_pkg::out_item_t status_due[$];
	lnsp_pkg::out_item_t due_word;

	// parser state as the bench sees it
	logic [7:0]  win[lnsp_pkg::WINDOW_DEPTH];
	logic [7:0]  node_buf[lnsp_pkg::NODE_LEN];
	int          node_pos      = 0;
	logic        lock_seen     = 1'b0;
	logic [31:0] byte_cnt      = '0;
	logic [31:0] node_cnt      = '0;
	logic [15:0] scan_cnt      = '0;
	logic [15:0] prev_scan_cnt = '0;
	logic [31:0] ms_now        = '0;
	logic [31:0] ms_last_byte  = '0;
	logic [31:0] ms_last_node  = '0;
	logic [15:0] timeout_ms    = lnsp_pkg::TIMEOUT_RESET;

	// traffic shaping
	logic        idle_off   = 1'b0;
	int          burst_left = 0;
	int          gap_left   = 0;
	logic [3:0]  stall_ctr  = '0;
	logic [3:0]  stall_len  = '0;

	int          mismatches = 0;
	int          queued     = 0;
	int          byte_phase = 0;

	lidar_node_stream_parser_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.timeout_we    (timeout_we),
		.timeout_wdata (timeout_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		foreach (win[i]) win[i] = '0;
		foreach (node_buf[i]) node_buf[i] = '0;
	end

	// Advance the parser by one word and return the status word it owes.
	function automatic lnsp_pkg::out_item_t parse_word(input lnsp_pkg::in_item_t w);
		lnsp_pkg::out_item_t r;
		logic                s;
		logic                inv;
		logic                chk;
		logic [15:0]         dist_val;
		int                  i;
		r = '0;
		if (w.command == lnsp_pkg::CMD_TICK) begin
			ms_now = ms_now + 32'd1;
		end else begin
			byte_cnt     = byte_cnt + 32'd1;
			ms_last_byte = ms_now;
			// shift the sync window; the oldest pair decides the lock
			for (i = 0; i < lnsp_pkg::WINDOW_DEPTH - 1; i++)
				win[i] = win[i + 1];
			win[lnsp_pkg::WINDOW_DEPTH - 1] = w.rx_byte;
			if (win[0] == lnsp_pkg::SYNC_FIRST && win[1] == lnsp_pkg::SYNC_SECOND)
				lock_seen = 1'b1;
			// node grouping runs free of the lock
			node_buf[node_pos] = w.rx_byte;
			node_pos++;
			if (node_pos == lnsp_pkg::NODE_LEN) begin
				node_pos        = 0;
				r.node_complete = 1'b1;
				s        = node_buf[lnsp_pkg::POS_FLAGS][0];
				inv      = node_buf[lnsp_pkg::POS_FLAGS][1];
				chk      = node_buf[lnsp_pkg::POS_CHECK][0];
				dist_val = {node_buf[lnsp_pkg::POS_LAST], node_buf[lnsp_pkg::POS_DIST_LO]};
				if (s != inv && chk && dist_val != 16'd0) begin
					r.node_accepted = 1'b1;
					if (s) begin
						r.scan_started = 1'b1;
						// an empty running count keeps the previous scan size
						if (scan_cnt != 16'd0)
							prev_scan_cnt = scan_cnt;
						scan_cnt = '0;
					end
					scan_cnt     = scan_cnt + 16'd1;
					node_cnt     = node_cnt + 32'd1;
					ms_last_node = ms_now;
				end
			end
		end
		r.locked            = lock_seen;
		r.byte_count        = byte_cnt;
		r.nodes_parsed      = node_cnt;
		r.scan_samples      = scan_cnt;
		r.last_scan_samples = prev_scan_cnt;
		r.last_node_ms      = ms_last_node;
		r.link_live         = (ms_now - ms_last_byte) <= {16'd0, timeout_ms};
		return r;
	endfunction

	// Driver: present the next pending word, in bursts with random gaps.
	// Predict a word at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!item_valid || item_ready) begin
			if (item_valid)
				status_due.push_back(parse_word(item));
			if (gap_left != 0 && !idle_off) begin
				item_valid <= 1'b0;
				gap_left   <= gap_left - 1;
			end else if (rx_pending.size() == 0) begin
				item_valid <= 1'b0;
			end else begin
				item       <= rx_pending.pop_front();
				item_valid <= 1'b1;
				// close the burst and pick the next gap; some bursts run on
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: stall while the free-running 4-bit counter is below a stall length
	// that changes each time it wraps, and check every accepted status word against the oldest one owed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_ctr    <= '0;
			stall_len    <= '0;
		end else begin
			if (result_valid && result_ready) begin
				if (status_due.size() == 0) begin
					$error("status word arrived with nothing owed");
					mismatches++;
				end else begin
					due_word = status_due.pop_front();
					check_field("locked", 32'(due_word.locked), 32'(result.locked));
					check_field("node_complete", 32'(due_word.node_complete),
						32'(result.node_complete));
					check_field("node_accepted", 32'(due_word.node_accepted),
						32'(result.node_accepted));
					check_field("scan_started", 32'(due_word.scan_started),
						32'(result.scan_started));
					check_field("byte_count", due_word.byte_count, result.byte_count);
					check_field("nodes_parsed", due_word.nodes_parsed, result.nodes_parsed);
					check_field("scan_samples", 32'(due_word.scan_samples),
						32'(result.scan_samples));
					check_field("last_scan_samples", 32'(due_word.last_scan_samples),
						32'(result.last_scan_samples));
					check_field("last_node_ms", due_word.last_node_ms, result.last_node_ms);
					check_field("link_live", 32'(due_word.link_live),
						32'(result.link_live));
				end
			end
			stall_ctr <= stall_ctr + 4'd1;
			if (stall_ctr == 4'hF)
				stall_len <= 4'($urandom_range(0, 12));
			result_ready <= idle_off || (stall_ctr >= stall_len);
		end
	end

	task automatic add_byte(input logic [7:0] b);
		lnsp_pkg::in_item_t w;
		w.command = lnsp_pkg::CMD_BYTE;
		w.rx_byte = b;
		rx_pending.push_back(w);
		queued++;
		byte_phase = (byte_phase + 1) % lnsp_pkg::NODE_LEN;
	endtask

	// The byte lane of a tick is don't-care; fill it with noise.
	task automatic add_tick();
		lnsp_pkg::in_item_t w;
		w.command = lnsp_pkg::CMD_TICK;
		w.rx_byte = 8'($urandom);
		rx_pending.push_back(w);
		queued++;
	endtask

	// Queue one node, bytes packed low to high; with run_max set, drop random
	// runs of ticks before any of its bytes.
	task automatic push_node(input logic [39:0] bytes, input int run_max);
		int i;
		for (i = 0; i < lnsp_pkg::NODE_LEN; i++) begin
			if (run_max != 0 && $urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, run_max)) add_tick();
			add_byte(bytes[8 * i +: 8]);
		end
	endtask

	// Wait until every word is sent and every status word is back, then
	// let the pipeline settle.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (rx_pending.size() != 0 || item_valid || status_due.size() != 0);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		wait_idle();
		timeout_we    <= 1'b1;
		timeout_wdata <= v;
		@(posedge clk);
		timeout_we <= 1'b0;
		timeout_ms = v;
	endtask

	// Mostly well-formed nodes with random content and tick runs; the rest is
	// loose bytes and stray sync pairs that shift the node grouping.
	task automatic random_traffic(input int n, input int run_max);
		int          first;
		int          kind;
		logic [7:0]  f;
		logic [7:0]  c;
		logic [15:0] d;
		first = queued;
		while (queued - first < n) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 7)) add_byte(8'($urandom));
			end else if (kind == 1) begin
				add_byte(lnsp_pkg::SYNC_FIRST);
				add_byte(lnsp_pkg::SYNC_SECOND);
			end else begin
				// pad back onto the node grid first
				while (byte_phase != 0)
					add_byte(8'($urandom));
				f    = 8'($urandom);
				f[0] = ($urandom_range(0, 7) == 0);
				f[1] = ($urandom_range(0, 9) == 0) ? f[0] : ~f[0];
				c    = 8'($urandom);
				c[0] = ($urandom_range(0, 9) != 0);
				d    = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
				push_node({d, 8'($urandom), c, f}, run_max);
			end
		end
	endtask

	initial begin
		int t;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset timeout. Start node on an empty count, a
		// zero-distance reject, the sync pair reaching the window's oldest
		// slots mid-stream, a plain accept, a missing check bit, then a start
		// node that saves a nonzero count.
		push_node({8'h00, 8'h5A, lnsp_pkg::SYNC_FIRST, 8'h01, 8'h01}, 0);
		push_node({8'h00, 8'h00, 8'h00, 8'hFF, 8'h02}, 0);
		add_tick();
		add_tick();
		push_node({8'h80, 8'hFF, 8'h77, 8'h01, 8'h02}, 0);
		push_node({8'h00, 8'h01, 8'h55, 8'hFE, 8'h02}, 0);
		push_node({8'h01, 8'h00, 8'h00, 8'h01, 8'h01}, 0);
		add_tick();

		// Zero timeout: any tick after a byte ends the stream.
		write_timeout(16'd0);
		random_traffic(150, 3);

		write_timeout(16'd3);
		random_traffic(350, 8);

		t = $urandom_range(1, 60);
		write_timeout(16'(t));
		random_traffic(350, (2 * t + 2 > 80) ? 80 : 2 * t + 2);

		// Widest timeout at full rate: hold active over a long idle run.
		write_timeout(16'hFFFF);
		idle_off <= 1'b1;
		add_byte(8'($urandom));
		repeat (40) add_tick();
		add_byte(8'($urandom));
		add_tick();

		// Full-rate node stream: a start node, a short scan of plain nodes, a start
		// node that saves the count, a plain node and a start node, no sender gaps.
		while (byte_phase != 0)
			add_byte(8'($urandom));
		push_node({8'h00, 8'h01, 8'h00, 8'h01, 8'h01}, 0);
		repeat (6)
			push_node({16'($urandom_range(1, 65535)), 8'($urandom), 8'h01, 8'h02}, 0);
		push_node({8'h01, 8'h00, 8'h00, 8'h01, 8'h01}, 0);
		push_node({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE}, 0);
		push_node({8'h12, 8'h34, 8'hFF, 8'hFF, 8'hFD}, 0);
		wait_idle();
		idle_off <= 1'b0;
		random_traffic(250, 20);

		write_timeout(lnsp_pkg::TIMEOUT_RESET);
		random_traffic(350, 40);

		write_timeout(16'($urandom));
		random_traffic(200, 40);

		wait_idle();
		repeat (PIPE_LAT + 8) @(posedge clk);
		if (mismatches == 0 && status_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Stop a hung run well past the slowest correct one.
	initial begin
		#(20_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
